>>> rtl/kvpt_pkg.sv
// shared types and constants for the key value parameter tokenizer
package kvpt_pkg;

  // parse phase codes
  localparam logic [2:0] PH_BEFORE_NAME  = 3'd0;
  localparam logic [2:0] PH_IN_NAME      = 3'd1;
  localparam logic [2:0] PH_AFTER_NAME   = 3'd2;
  localparam logic [2:0] PH_BEFORE_VALUE = 3'd3;
  localparam logic [2:0] PH_VAL_DQ       = 3'd4;
  localparam logic [2:0] PH_VAL_SQ       = 3'd5;
  localparam logic [2:0] PH_VAL_UNQ      = 3'd6;
  localparam logic [2:0] PH_DONE         = 3'd7;

  // result kind codes
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;

  // special bytes
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [7:0] SEP_RESET = 8'h3B;

  // result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last_of_run;
  } result_t;

  // outcome of one input item
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    logic [2:0] phase_next;
  } step_t;

endpackage

>>> rtl/kvpt_if.sv
// valid/ready channel interfaces for input bytes and result items
interface kvpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

interface kvpt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output kind, output char_out, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input char_out, input last_of_run,
                output ready);
endinterface

>>> rtl/kvpt_step.sv
// per-byte parse rules: next phase and up to two result items
module kvpt_step
  import kvpt_pkg::*;
(
  input  logic [2:0] phase,
  input  logic [7:0] separator,
  input  logic [7:0] char_in,
  input  logic       end_of_string,
  output step_t      step
);

  logic       is_ws;
  logic       is_crlf;
  logic       m_emit;
  logic [1:0] m_kind;
  logic [7:0] m_char;
  logic [2:0] mid;
  logic       closes;
  logic       f_emit;
  result_t    pair_res;

  assign is_crlf = (char_in == CH_CR) || (char_in == CH_LF);
  assign is_ws   = is_crlf || (char_in == CH_SPACE) || (char_in == CH_TAB);
  assign closes  = ((phase == PH_VAL_DQ) && (char_in == CH_DQUOTE)) ||
                   ((phase == PH_VAL_SQ) && (char_in == CH_SQUOTE));

  // per-phase rules for an ordinary byte
  always_comb begin
    m_emit = 1'b0;
    m_kind = KIND_NAME;
    m_char = char_in;
    mid    = phase;
    unique case (phase) inside
      PH_BEFORE_NAME: begin
        if (char_in != separator && !is_ws) begin
          m_emit = 1'b1;
          mid    = PH_IN_NAME;
        end
      end
      PH_IN_NAME: begin
        if (!is_ws && char_in != CH_EQUALS && char_in != separator) begin
          m_emit = 1'b1;
        end else if (char_in == CH_EQUALS) begin
          mid = PH_BEFORE_VALUE;
        end else if (char_in == separator) begin
          m_emit = 1'b1;
          m_kind = KIND_PAIR;
          m_char = 8'd0;
          mid    = PH_BEFORE_NAME;
        end else begin
          mid = PH_AFTER_NAME;
        end
      end
      PH_AFTER_NAME: begin
        if (char_in == CH_EQUALS) begin
          mid = PH_BEFORE_VALUE;
        end
      end
      PH_BEFORE_VALUE: begin
        if (!is_ws) begin
          if (char_in == CH_DQUOTE) begin
            mid = PH_VAL_DQ;
          end else if (char_in == CH_SQUOTE) begin
            mid = PH_VAL_SQ;
          end else begin
            m_emit = 1'b1;
            m_kind = KIND_VALUE;
            mid    = PH_VAL_UNQ;
          end
        end
      end
      PH_VAL_DQ, PH_VAL_SQ, PH_VAL_UNQ: begin
        m_emit = 1'b1;
        if (char_in == separator || closes) begin
          m_kind = KIND_PAIR;
          m_char = 8'd0;
          mid    = PH_BEFORE_NAME;
        end else begin
          m_kind = KIND_VALUE;
        end
      end
      PH_DONE: begin
        mid = PH_DONE;
      end
      default: begin
        mid = phase;
      end
    endcase
  end

  assign pair_res = '{kind: KIND_PAIR, char_out: 8'd0, last_of_run: 1'b1};

  // record end, done phase and final-byte flush
  always_comb begin
    step.r0 = pair_res;
    step.r1 = pair_res;
    f_emit  = 1'b0;
    if (phase == PH_DONE) begin
      step.count      = 2'd0;
      step.phase_next = end_of_string ? PH_BEFORE_NAME : PH_DONE;
    end else if (is_crlf) begin
      f_emit          = (phase != PH_BEFORE_NAME);
      step.count      = {1'b0, f_emit};
      step.phase_next = end_of_string ? PH_BEFORE_NAME : PH_DONE;
    end else begin
      f_emit          = end_of_string && (mid != PH_BEFORE_NAME);
      step.count      = {1'b0, m_emit} + {1'b0, f_emit};
      step.phase_next = end_of_string ? PH_BEFORE_NAME : mid;
      if (m_emit) begin
        step.r0.kind        = m_kind;
        step.r0.char_out    = m_char;
        step.r0.last_of_run = !f_emit;
      end
    end
  end

endmodule

>>> rtl/kvpt_queue.sv
// small result queue: takes up to two items per cycle, gives one
module kvpt_queue
  import kvpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  result_t           push_r0,
  input  result_t           push_r1,
  output logic              room,
  kvpt_out_if.source        tokens
);

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QPTR_W-1:0]   wr_ptr_next1;
  logic                pop;
  result_t             head;

  // room for a worst-case item of two results
  assign room         = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop          = tokens.valid && tokens.ready;
  assign wr_ptr_next1 = wr_ptr + QPTR_W'(1);

  // result output
  assign head               = slots[rd_ptr];
  assign tokens.valid       = (count != '0);
  assign tokens.kind        = head.kind;
  assign tokens.char_out    = head.char_out;
  assign tokens.last_of_run = head.last_of_run;

  // slot writes
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_r0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr_next1] <= push_r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

endmodule

>>> rtl/key_value_param_tokenizer_core.sv
// top level of the key value parameter tokenizer
//
// Usage: bytes of a parameter string such as name=value;n2="v 2" enter on the
// chars channel, one per item, with end_of_string set on the last byte.
// Result items leave on the tokens channel: name bytes, value bytes and a
// pair-complete marker, with last_of_run set on the final result of a byte.
// The user must write the separator byte through sep_we/sep_wdata only while
// idle; the block itself does not enforce this. Results of a byte are
// registered in the result queue. Throughput: one byte per cycle while
// chars.ready is high, limited by the single result port when a byte yields
// two results (a two-slot step into a four-entry result queue). chars.ready
// is high while the queue has at least two free slots, so a stalled receiver
// backs up into the byte stream after at most four results are held. Reset
// clears the parse phase and the queue and sets the separator to ';'.
module key_value_param_tokenizer_core
  import kvpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sep_we,
  input  logic [7:0]  sep_wdata,
  kvpt_in_if.sink     chars,
  kvpt_out_if.source  tokens
);

  logic [2:0] phase;
  logic [7:0] separator;
  step_t      step;
  logic       room;
  logic       accept;
  logic [1:0] push_count;

  assign chars.ready = room;
  assign accept      = chars.valid && room;
  assign push_count  = accept ? step.count : 2'd0;

  // separator register
  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= SEP_RESET;
    end else if (sep_we) begin
      separator <= sep_wdata;
    end
  end

  // parse phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BEFORE_NAME;
    end else if (accept) begin
      phase <= step.phase_next;
    end
  end

  // per-byte rules
  kvpt_step u_step (
    .phase         (phase),
    .separator     (separator),
    .char_in       (chars.char_in),
    .end_of_string (chars.end_of_string),
    .step          (step)
  );

  // result queue
  kvpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_r0    (step.r0),
    .push_r1    (step.r1),
    .room       (room),
    .tokens     (tokens)
  );

endmodule
